[rtl/hrbp_pkg.sv]
// Package for the HTTP request byte parser.
// Holds word types, role and status codes and the fixed match strings.
// No dependencies.
package hrbp_pkg;

   localparam int ROLE_BITS = 4;
   localparam int STATUS_BITS = 2;
   localparam int OUT_LEN_BITS = 32;
   localparam int FORM_CHARS = 33;

   localparam logic [STATUS_BITS-1:0] ST_PARSING = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_BODY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_BAD     = 2'd3;

   localparam logic [ROLE_BITS-1:0] R_NONE   = 4'd0;
   localparam logic [ROLE_BITS-1:0] R_METHOD = 4'd1;
   localparam logic [ROLE_BITS-1:0] R_PATH   = 4'd2;
   localparam logic [ROLE_BITS-1:0] R_QKEY   = 4'd3;
   localparam logic [ROLE_BITS-1:0] R_QVAL   = 4'd4;
   localparam logic [ROLE_BITS-1:0] R_PROTO  = 4'd5;
   localparam logic [ROLE_BITS-1:0] R_VER    = 4'd6;
   localparam logic [ROLE_BITS-1:0] R_HKEY   = 4'd7;
   localparam logic [ROLE_BITS-1:0] R_HVAL   = 4'd8;
   localparam logic [ROLE_BITS-1:0] R_BODY   = 4'd9;
   localparam logic [ROLE_BITS-1:0] R_FKEY   = 4'd10;
   localparam logic [ROLE_BITS-1:0] R_FVAL   = 4'd11;

   localparam logic [7:0] C_CR = 8'd13;
   localparam logic [7:0] C_LF = 8'd10;

   localparam logic [14*8-1:0] LEN_NAME  = "Content-Length";
   localparam logic [12*8-1:0] TYPE_NAME = "Content-Type";
   localparam logic [4*8-1:0]  POST_NAME = "POST";
   localparam logic [FORM_CHARS*8-1:0] FORM_TYPE = "application/x-www-form-urlencoded";

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [ROLE_BITS-1:0]    byte_role;
      logic [ROLE_BITS-1:0]    field_end;
      logic [OUT_LEN_BITS-1:0] parsed_length;
      logic                    form_mode;
   } rsp_word_type;

   function automatic logic [7:0] len_char(input logic [3:0] p);
      logic [7:0] c;
      c = 8'd0;
      for (int i = 0; i < 14; i++) begin
         if (p == 4'(i)) c = LEN_NAME[8*(13-i) +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] type_char(input logic [3:0] p);
      logic [7:0] c;
      c = 8'd0;
      for (int i = 0; i < 12; i++) begin
         if (p == 4'(i)) c = TYPE_NAME[8*(11-i) +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] post_char(input logic [2:0] p);
      logic [7:0] c;
      c = 8'd0;
      for (int i = 0; i < 4; i++) begin
         if (p == 3'(i)) c = POST_NAME[8*(3-i) +: 8];
      end
      return c;
   endfunction

endpackage

[rtl/hrbp_length.sv]
// Saturating decimal step for the Content-Length value: len * 10 + digit.
// Depends on nothing but its parameter.
module hrbp_length #(
   parameter int LENGTH_BITS = 32
) (
   input  logic [LENGTH_BITS-1:0] len,
   input  logic [3:0]             digit,
   output logic [LENGTH_BITS-1:0] len_next
);
   logic [LENGTH_BITS+3:0] wide;

   // Times ten as two shifts; the sum overflows exactly when it exceeds the maximum.
   assign wide = ({4'd0, len} << 3) + ({4'd0, len} << 1) + {{LENGTH_BITS{1'b0}}, digit};
   assign len_next = (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? {LENGTH_BITS{1'b1}}
                                                                : wide[LENGTH_BITS-1:0];
endmodule

[rtl/hrbp_window.sv]
// Sliding window over Content-Type value bytes that spots the form media type.
// Depends on hrbp_pkg.
module hrbp_window
   import hrbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       shift,
   input  logic [7:0] byte_value,
   output logic       match
);
   // The oldest byte falls out on the shift that compares, so 32 bytes are kept.
   logic [(FORM_CHARS-1)*8-1:0] win_ff, win_in;

   assign match = ({win_ff, byte_value} == FORM_TYPE);

   always_comb begin
      win_in = win_ff;
      if (clear) win_in = '0;
      else if (shift) win_in = {win_ff[(FORM_CHARS-2)*8-1:0], byte_value};
   end

   always_ff @(posedge clock) begin
      if (reset) win_ff <= '0;
      else win_ff <= win_in;
   end
endmodule

[rtl/http_request_byte_parser.sv]
// HTTP request byte parser: one word (a byte or a restart) in, one tagged word out.
// Every accepted word yields exactly one result word in the next cycle, and a new word
// can be taken in every cycle; the parse state update and the result register sit in
// a single stage, so throughput is one byte per clock while rsp_stall is low.
// Content-Length is kept to LENGTH_BITS bits, saturating, and shown as its low 32 bits.
module http_request_byte_parser
   import hrbp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);
   typedef enum logic [4:0] {
      P_START, P_METHOD, P_PRE_PATH, P_PATH, P_PRE_QKEY, P_QKEY, P_PRE_QVAL, P_QVAL,
      P_PRE_PROTO, P_PROTO, P_PRE_VER, P_VER, P_HKEY, P_HVAL, P_GOT_CR, P_GOT_CRLF,
      P_GOT_CRLFCR, P_BODY, P_DONE, P_BAD
   } pstate_type;

   pstate_type             state_ff, state_in;
   logic [2:0]             mpos_ff, mpos_in;
   logic                   post_ff, post_in;
   logic [3:0]             npos_ff, npos_in;
   logic [1:0]             hits_ff, hits_in;
   logic                   lead_ff, lead_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_step;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                   form_ff, form_in;
   logic                   fval_ff, fval_in;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_ff, rsp_in;
   logic                   accept, win_clear, win_shift, win_match;
   logic [7:0]             b;
   logic [ROLE_BITS-1:0]   role, fend;
   logic                   blank, digit, upper;
   logic [63:0]            len_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b     = req_data.byte_value;
   assign blank = (b == 8'h20) || (b == 8'h09);
   assign digit = (b >= "0") && (b <= "9");
   assign upper = (b >= "A") && (b <= "Z");

   hrbp_length #(.LENGTH_BITS(LENGTH_BITS)) u_length (
      .len(len_ff), .digit(b[3:0] - 4'd0), .len_next(len_step)
   );

   hrbp_window u_window (
      .clock(clock), .reset(reset), .clear(win_clear), .shift(win_shift),
      .byte_value(b), .match(win_match)
   );

   always_comb begin
      logic [1:0] kind;
      logic [1:0] h;
      logic [3:0] p;
      state_in  = state_ff;
      mpos_in   = mpos_ff;
      post_in   = post_ff;
      npos_in   = npos_ff;
      hits_in   = hits_ff;
      lead_in   = lead_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      form_in   = form_ff;
      fval_in   = fval_ff;
      win_clear = 1'b0;
      win_shift = 1'b0;
      role      = R_NONE;
      fend      = R_NONE;
      kind      = 2'd0;
      h         = 2'd0;
      p         = 4'd0;
      if (req_data.action) begin
         state_in  = P_START;
         mpos_in   = 3'd0;
         post_in   = 1'b0;
         npos_in   = 4'd0;
         hits_in   = 2'd0;
         lead_in   = 1'b1;
         len_in    = '0;
         rem_in    = '0;
         form_in   = 1'b0;
         fval_in   = 1'b0;
         win_clear = 1'b1;
      end else begin
         case (state_ff)
            P_START: begin
               if (b == C_CR || b == C_LF || blank) begin
               end else if (upper) begin
                  mpos_in  = (b == post_char(3'd0)) ? 3'd1 : 3'd7;
                  role     = R_METHOD;
                  state_in = P_METHOD;
               end else state_in = P_BAD;
            end
            P_METHOD: begin
               if (upper) begin
                  mpos_in = (mpos_ff < 3'd4 && b == post_char(mpos_ff)) ? mpos_ff + 3'd1
                                                                         : 3'd7;
                  role = R_METHOD;
               end else if (blank) begin
                  post_in  = (mpos_ff == 3'd4);
                  fend     = R_METHOD;
                  state_in = P_PRE_PATH;
               end else state_in = P_BAD;
            end
            P_PRE_PATH: begin
               if (b == "/") begin
                  role = R_PATH; state_in = P_PATH;
               end else if (!blank) state_in = P_BAD;
            end
            P_PATH: begin
               if (b == "?") begin
                  fend = R_PATH; state_in = P_PRE_QKEY;
               end else if (blank) begin
                  fend = R_PATH; state_in = P_PRE_PROTO;
               end else role = R_PATH;
            end
            P_PRE_QKEY: begin
               if (blank || b == C_CR || b == C_LF) state_in = P_BAD;
               else begin
                  role = R_QKEY; state_in = P_QKEY;
               end
            end
            P_QKEY: begin
               if (b == "=") begin
                  fend = R_QKEY; state_in = P_PRE_QVAL;
               end else if (blank) state_in = P_BAD;
               else role = R_QKEY;
            end
            P_PRE_QVAL: begin
               if (blank || b == C_CR || b == C_LF) state_in = P_BAD;
               else begin
                  role = R_QVAL; state_in = P_QVAL;
               end
            end
            P_QVAL: begin
               if (b == "&") begin
                  fend = R_QVAL; state_in = P_PRE_QKEY;
               end else if (blank) begin
                  fend = R_QVAL; state_in = P_PRE_PROTO;
               end else role = R_QVAL;
            end
            P_PRE_PROTO: begin
               if (!blank) begin
                  role = R_PROTO; state_in = P_PROTO;
               end
            end
            P_PROTO: begin
               if (b == "/") begin
                  fend = R_PROTO; state_in = P_PRE_VER;
               end else role = R_PROTO;
            end
            P_PRE_VER: begin
               if (digit) begin
                  role = R_VER; state_in = P_VER;
               end else state_in = P_BAD;
            end
            P_VER: begin
               if (b == C_CR) begin
                  fend = R_VER; state_in = P_GOT_CR;
               end else if (digit || b == ".") role = R_VER;
               else state_in = P_BAD;
            end
            P_HKEY: begin
               if (b == ":") begin
                  if (hits_ff[0] && npos_ff == 4'd14) kind = 2'd1;
                  else if (hits_ff[1] && npos_ff == 4'd12) kind = 2'd2;
                  hits_in = kind;
                  npos_in = 4'd0;
                  lead_in = 1'b1;
                  if (kind == 2'd1) len_in = '0;
                  if (kind == 2'd2) begin
                     win_clear = 1'b1;
                     form_in   = 1'b0;
                  end
                  fend     = R_HKEY;
                  state_in = P_HVAL;
               end else begin
                  h = hits_ff;
                  p = npos_ff;
                  if (h[0] && !(p < 4'd14 && b == len_char(p))) h[0] = 1'b0;
                  if (h[1] && !(p < 4'd12 && b == type_char(p))) h[1] = 1'b0;
                  hits_in = h;
                  if (p < 4'd15) npos_in = p + 4'd1;
                  role = R_HKEY;
               end
            end
            P_HVAL: begin
               if (lead_ff && blank) begin
               end else if (b == C_CR) begin
                  fend = R_HVAL; state_in = P_GOT_CR;
               end else begin
                  lead_in = 1'b0;
                  if (hits_ff == 2'd1 && npos_ff == 4'd0) begin
                     if (digit) len_in = len_step;
                     else if (!(lead_ff && b == "+")) npos_in = 4'd1;
                  end else if (hits_ff == 2'd2) begin
                     win_shift = 1'b1;
                     if (win_match) form_in = 1'b1;
                  end
                  role = R_HVAL;
               end
            end
            P_GOT_CR: state_in = (b == C_LF) ? P_GOT_CRLF : P_BAD;
            P_GOT_CRLF: begin
               if (b == C_CR) state_in = P_GOT_CRLFCR;
               else if (blank) state_in = P_BAD;
               else begin
                  h[0] = (b == len_char(4'd0));
                  h[1] = (b == type_char(4'd0));
                  hits_in  = h;
                  npos_in  = 4'd1;
                  role     = R_HKEY;
                  state_in = P_HKEY;
               end
            end
            P_GOT_CRLFCR: begin
               if (b == C_LF) begin
                  fval_in = 1'b0;
                  if (len_ff != '0) begin
                     rem_in   = len_ff;
                     form_in  = form_ff && post_ff;
                     state_in = P_BODY;
                  end else begin
                     form_in  = 1'b0;
                     state_in = P_DONE;
                  end
               end else state_in = P_BAD;
            end
            P_BODY: begin
               if (form_ff) begin
                  if (!fval_ff) begin
                     if (b == "=") begin
                        fend = R_FKEY; fval_in = 1'b1;
                     end else role = R_FKEY;
                  end else begin
                     if (b == "&") begin
                        fend = R_FVAL; fval_in = 1'b0;
                     end else role = R_FVAL;
                  end
               end else role = R_BODY;
               if (rem_ff <= LENGTH_BITS'(1)) begin
                  rem_in   = '0;
                  state_in = P_DONE;
                  if (!form_ff) fend = R_BODY;
                  else if (fend == R_NONE && fval_in) fend = R_FVAL;
               end else rem_in = rem_ff - LENGTH_BITS'(1);
            end
            P_DONE: begin
            end
            default: state_in = P_BAD;
         endcase
      end

      // The window holds state of its own, so it may only move on an accepted word.
      win_clear = win_clear && accept;
      win_shift = win_shift && accept;

      len_ext = 64'(len_in);
      rsp_in.byte_role     = role;
      rsp_in.field_end     = fend;
      rsp_in.parsed_length = len_ext[OUT_LEN_BITS-1:0];
      case (state_in)
         P_BODY:  rsp_in.status = ST_BODY;
         P_DONE:  rsp_in.status = ST_DONE;
         P_BAD:   rsp_in.status = ST_BAD;
         default: rsp_in.status = ST_PARSING;
      endcase
      rsp_in.form_mode = (state_in == P_BODY || state_in == P_DONE) ? form_in : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= P_START;
         mpos_ff      <= 3'd0;
         post_ff      <= 1'b0;
         npos_ff      <= 4'd0;
         hits_ff      <= 2'd0;
         lead_ff      <= 1'b1;
         len_ff       <= '0;
         rem_ff       <= '0;
         form_ff      <= 1'b0;
         fval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            mpos_ff  <= mpos_in;
            post_ff  <= post_in;
            npos_ff  <= npos_in;
            hits_ff  <= hits_in;
            lead_ff  <= lead_in;
            len_ff   <= len_in;
            rem_ff   <= rem_in;
            form_ff  <= form_in;
            fval_ff  <= fval_in;
            rsp_ff   <= rsp_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   // Window updates must only follow accepted words.
   a_window_gated: assert property (@(posedge clock) disable iff (reset)
      (win_shift || win_clear) |-> accept)
      else $error("window updated without an accepted word");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_BODY) |-> (rem_ff != '0))
      else $error("body state with no bytes remaining");

   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_BAD) |->
      (rsp_data.byte_role == R_NONE && rsp_data.field_end == R_NONE && !rsp_data.form_mode))
      else $error("invalid result carries a role or form flag");

   a_form_in_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.form_mode) |->
      (rsp_data.status == ST_BODY || rsp_data.status == ST_DONE))
      else $error("form mode outside the body");
`endif
endmodule

[tb/sv/http_request_byte_parser_test.sv]
// Testbench for the HTTP request byte parser: directed and random request streams.
// Depends on hrbp_pkg and http_request_byte_parser; predicts every result word itself.
`timescale 1ns / 1ps

module http_request_byte_parser_test
   import hrbp_pkg::*;
;

   typedef enum logic [4:0] {
      PS_START, PS_METHOD, PS_PRE_PATH, PS_PATH, PS_PRE_QKEY, PS_QKEY, PS_PRE_QVAL,
      PS_QVAL, PS_PRE_PROTO, PS_PROTO, PS_PRE_VER, PS_VER, PS_HKEY, PS_HVAL,
      PS_GOT_CR, PS_GOT_CRLF, PS_GOT_CRLFCR, PS_BODY, PS_DONE, PS_BAD
   } parse_state_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   bit           req_taken = 1'b0;

   http_request_byte_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state.
   parse_state_type ps;
   logic [2:0]  m_pos;
   logic        m_post;
   logic [3:0]  h_pos;
   logic [1:0]  h_hits;
   logic        v_lead;
   logic [31:0] len_acc;
   logic [31:0] body_left;
   logic [FORM_CHARS*8-1:0] type_win;
   logic        f_flag;
   logic        f_val;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_sender = 0;
   bit stim_done = 0;
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int quiet_cycles = 0;
   int complete_count = 0;
   int form_count = 0;

   function automatic bit is_blank(logic [7:0] b);
      return b == 8'h20 || b == 8'h09;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_upper(logic [7:0] b);
      return b >= "A" && b <= "Z";
   endfunction

   function automatic logic [7:0] str_char(string s, int i);
      return (i < s.len()) ? s[i] : 8'd0;
   endfunction

   function automatic void clear_parser();
      ps = PS_START; m_pos = 0; m_post = 0; h_pos = 0; h_hits = 0; v_lead = 1;
      len_acc = 0; body_left = 0; type_win = '0; f_flag = 0; f_val = 0;
   endfunction

   function automatic void track_method(logic [7:0] b);
      if (m_pos < 4 && b == str_char("POST", m_pos)) m_pos = m_pos + 1;
      else m_pos = 7;
   endfunction

   function automatic void track_name(logic [7:0] b);
      if (h_hits[0] && !(h_pos < 14 && b == str_char("Content-Length", h_pos)))
         h_hits = h_hits & 2'd2;
      if (h_hits[1] && !(h_pos < 12 && b == str_char("Content-Type", h_pos)))
         h_hits = h_hits & 2'd1;
      if (h_pos < 15) h_pos = h_pos + 1;
   endfunction

   function automatic void close_name();
      logic [1:0] kind;
      kind = 0;
      if (h_hits[0] && h_pos == 14) kind = 1;
      else if (h_hits[1] && h_pos == 12) kind = 2;
      h_hits = kind; h_pos = 0; v_lead = 1;
      if (kind == 1) len_acc = 0;
      if (kind == 2) begin
         type_win = '0; f_flag = 0;
      end
   endfunction

   function automatic void take_value(logic [7:0] b);
      logic first;
      logic [32:0] wide;
      first = v_lead;
      v_lead = 0;
      if (h_hits == 1 && h_pos == 0) begin
         if (is_digit(b)) begin
            wide = {1'b0, len_acc} * 33'd10 + 33'(b - "0");
            if (len_acc > 32'd429496729 || wide[32]) len_acc = '1;
            else len_acc = wide[31:0];
         end else if (!(first && b == "+")) begin
            h_pos = 1;
         end
      end else if (h_hits == 2) begin
         type_win = {type_win[FORM_CHARS*8-9:0], b};
         if (type_win == FORM_TYPE) f_flag = 1;
      end
   endfunction

   function automatic rsp_word_type predict_word(req_word_type w);
      rsp_word_type r;
      logic [7:0] b;
      logic [3:0] role, fend;
      b = w.byte_value;
      role = R_NONE;
      fend = R_NONE;
      if (w.action) begin
         clear_parser();
      end else begin
         case (ps)
            PS_START:
               if (b == C_CR || b == C_LF || is_blank(b)) ;
               else if (is_upper(b)) begin
                  m_pos = 0; track_method(b); role = R_METHOD; ps = PS_METHOD;
               end else ps = PS_BAD;
            PS_METHOD:
               if (is_upper(b)) begin
                  track_method(b); role = R_METHOD;
               end else if (is_blank(b)) begin
                  m_post = (m_pos == 4); fend = R_METHOD; ps = PS_PRE_PATH;
               end else ps = PS_BAD;
            PS_PRE_PATH:
               if (b == "/") begin
                  role = R_PATH; ps = PS_PATH;
               end else if (!is_blank(b)) ps = PS_BAD;
            PS_PATH:
               if (b == "?") begin
                  fend = R_PATH; ps = PS_PRE_QKEY;
               end else if (is_blank(b)) begin
                  fend = R_PATH; ps = PS_PRE_PROTO;
               end else role = R_PATH;
            PS_PRE_QKEY:
               if (is_blank(b) || b == C_CR || b == C_LF) ps = PS_BAD;
               else begin
                  role = R_QKEY; ps = PS_QKEY;
               end
            PS_QKEY:
               if (b == "=") begin
                  fend = R_QKEY; ps = PS_PRE_QVAL;
               end else if (is_blank(b)) ps = PS_BAD;
               else role = R_QKEY;
            PS_PRE_QVAL:
               if (is_blank(b) || b == C_CR || b == C_LF) ps = PS_BAD;
               else begin
                  role = R_QVAL; ps = PS_QVAL;
               end
            PS_QVAL:
               if (b == "&") begin
                  fend = R_QVAL; ps = PS_PRE_QKEY;
               end else if (is_blank(b)) begin
                  fend = R_QVAL; ps = PS_PRE_PROTO;
               end else role = R_QVAL;
            PS_PRE_PROTO:
               if (!is_blank(b)) begin
                  role = R_PROTO; ps = PS_PROTO;
               end
            PS_PROTO:
               if (b == "/") begin
                  fend = R_PROTO; ps = PS_PRE_VER;
               end else role = R_PROTO;
            PS_PRE_VER:
               if (is_digit(b)) begin
                  role = R_VER; ps = PS_VER;
               end else ps = PS_BAD;
            PS_VER:
               if (b == C_CR) begin
                  fend = R_VER; ps = PS_GOT_CR;
               end else if (is_digit(b) || b == ".") role = R_VER;
               else ps = PS_BAD;
            PS_HKEY:
               if (b == ":") begin
                  close_name(); fend = R_HKEY; ps = PS_HVAL;
               end else begin
                  track_name(b); role = R_HKEY;
               end
            PS_HVAL:
               if (v_lead && is_blank(b)) ;
               else if (b == C_CR) begin
                  fend = R_HVAL; ps = PS_GOT_CR;
               end else begin
                  take_value(b); role = R_HVAL;
               end
            PS_GOT_CR: ps = (b == C_LF) ? PS_GOT_CRLF : PS_BAD;
            PS_GOT_CRLF:
               if (b == C_CR) ps = PS_GOT_CRLFCR;
               else if (is_blank(b)) ps = PS_BAD;
               else begin
                  h_pos = 0; h_hits = 3; track_name(b); role = R_HKEY; ps = PS_HKEY;
               end
            PS_GOT_CRLFCR:
               if (b == C_LF) begin
                  f_val = 0;
                  if (len_acc > 0) begin
                     body_left = len_acc; f_flag = f_flag && m_post; ps = PS_BODY;
                  end else begin
                     f_flag = 0; ps = PS_DONE;
                  end
               end else ps = PS_BAD;
            PS_BODY: begin
               if (f_flag) begin
                  if (!f_val) begin
                     if (b == "=") begin
                        fend = R_FKEY; f_val = 1;
                     end else role = R_FKEY;
                  end else begin
                     if (b == "&") begin
                        fend = R_FVAL; f_val = 0;
                     end else role = R_FVAL;
                  end
               end else role = R_BODY;
               if (body_left <= 1) begin
                  body_left = 0; ps = PS_DONE;
                  if (!f_flag) fend = R_BODY;
                  else if (fend == R_NONE && f_val) fend = R_FVAL;
               end else body_left = body_left - 1;
            end
            PS_DONE: ;
            default: ps = PS_BAD;
         endcase
      end
      case (ps)
         PS_BODY: r.status = ST_BODY;
         PS_DONE: r.status = ST_DONE;
         PS_BAD:  r.status = ST_BAD;
         default: r.status = ST_PARSING;
      endcase
      r.byte_role = role;
      r.field_end = fend;
      r.parsed_length = len_acc;
      r.form_mode = (ps == PS_BODY || ps == PS_DONE) ? f_flag : 1'b0;
      return r;
   endfunction

   // Stimulus helpers.
   task automatic push_byte(logic [7:0] b);
      req_word_type w;
      w.action = 1'b0;
      w.byte_value = b;
      pending_words.push_back(w);
   endtask

   task automatic push_restart();
      req_word_type w;
      w.action = 1'b1;
      w.byte_value = 8'($urandom);
      pending_words.push_back(w);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_token_char();
      string pool;
      pool = "abcxyzAZ09-_.%+/=&?";
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   function automatic string rand_token(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(rand_token_char())};
      return s;
   endfunction

   // One request, mostly well formed, sometimes broken or with noise bytes.
   task automatic push_request();
      string meth, body, lead, sign;
      int blen, corrupt;
      bit form;
      logic [7:0] c;
      meth = ($urandom_range(2) == 0) ? "GET" : "POST";
      form = $urandom_range(1) && meth == "POST";
      corrupt = $urandom_range(9);
      push_restart();
      push_text({meth, " /", rand_token($urandom_range(0, 6))});
      if ($urandom_range(1)) push_text({"?k", rand_token($urandom_range(2)), "=v&a=b"});
      push_text(" HTTP/1.1\r\n");
      if ($urandom_range(3) == 0) push_text({"X-", rand_token(3), ": ", rand_token(4), "\r\n"});
      blen = $urandom_range(0, 12);
      body = "";
      for (int i = 0; i < blen; i++) begin
         if (!form) c = rand_token_char();
         else if ($urandom_range(3) == 0) c = "=";
         else if ($urandom_range(3) == 0) c = "&";
         else c = "q";
         body = {body, string'(c)};
      end
      if (blen > 0 || $urandom_range(1)) begin
         lead = "";
         sign = "";
         if ($urandom_range(1)) lead = " \t";
         if ($urandom_range(3) == 0) sign = "+";
         push_text({"Content-Length:", lead, sign, $sformatf("%0d", blen), "\r\n"});
      end
      if (form) push_text("Content-Type: application/x-www-form-urlencoded\r\n");
      if (corrupt == 0) push_byte(8'($urandom));
      push_text("\r\n");
      push_text(body);
      if (corrupt == 1) push_text(rand_token($urandom_range(1, 4)));
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clock);
   endtask

   // Acceptance is observed at the rising edge; the driver acts on it at the next
   // falling edge, where a new word may be presented from the head of the queue.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_taken) begin
            expected_words.push_back(predict_word(req_data));
            words_in++;
            void'(pending_words.pop_front());
         end
         if (!req_valid || req_taken) begin
            if (!hold_sender && pending_words.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", rsp_data);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.status == ST_DONE && want.status == ST_DONE &&
                rsp_data.field_end != R_NONE) complete_count++;
            if (want.form_mode) form_count++;
            if (rsp_data !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected st=%0d role=%0d end=%0d len=%0d fm=%0d,",
                            " got st=%0d role=%0d end=%0d len=%0d fm=%0d"},
                     want.status, want.byte_role, want.field_end, want.parsed_length,
                     want.form_mode, rsp_data.status, rsp_data.byte_role,
                     rsp_data.field_end, rsp_data.parsed_length, rsp_data.form_mode);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else if (pending_words.size() != 0 || expected_words.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", expected_words.size());
            $display("http_request_byte_parser_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed: a complete form POST, its length and content type in separate headers.
      push_text("\r\n POST /a?k=v&x=y HTTP/1.1\r\n");
      push_text("Content-Length:  +5\r\nContent-Type:application/x-www-form-urlencoded\r\n\r\n");
      push_text("a=b&c");
      push_byte(8'hFF);
      push_restart();
      push_text("GET / H/1.0\r\nContent-Length: 99999999999x\r\n\r\n");
      push_restart();
      push_text("Get /");
      push_restart();
      push_byte(8'h00);
      push_restart();
      push_text("PUT /p HTTP/1.1\r\nContent-Length: -3\r\n\r\n");
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = (phase == 1 || phase == 3) ? 48 : 0;
         receiver_stall_pct = (phase == 2 || phase == 3) ? 48 : 0;
         if (phase == 3) begin
            sender_idle_pct = 14;
            receiver_stall_pct = 14;
         end
         while (pending_words.size() < 230) begin
            if ($urandom_range(9) == 0) push_byte(8'($urandom));
            else push_request();
         end
         wait_drained();
         hold_sender = 1;
         repeat (5) @(posedge clock);
         hold_sender = 0;
      end
      wait_drained();
      repeat (10) @(posedge clock);
      $display("Fed %0d words, checked %0d results; %0d body ends, %0d form-mode words.",
               words_in, words_out, complete_count, form_count);
      if (errors == 0) begin
         $display("http_request_byte_parser_test OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("http_request_byte_parser_test NOT OK");
      end
      $finish;
   end

endmodule

[http_request_byte_parser.f]
rtl/hrbp_pkg.sv
rtl/hrbp_length.sv
rtl/hrbp_window.sv
rtl/http_request_byte_parser.sv
tb/sv/http_request_byte_parser_test.sv
